// ----- sv/xlb_pkg.sv -----
// Shared types and constants for the XOR linear basis engine.
// Holds opcodes, status codes, payload structs and the sequencer status struct.
// No dependencies.
`default_nettype none

package xlb_pkg;

  localparam int VALUE_BITS = 63;
  localparam int IDX_W      = 6;
  localparam int CNT_W      = 7;

  localparam logic [IDX_W-1:0] TOP_IDX = IDX_W'(VALUE_BITS - 1);

  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_MAX    = 3'd1;
  localparam logic [2:0] OP_MIN    = 3'd2;
  localparam logic [2:0] OP_REDUCE = 3'd3;
  localparam logic [2:0] OP_KTH    = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_DEPENDENT = 2'd1;
  localparam logic [1:0] ST_RANGE     = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  typedef struct packed {
    logic [2:0]            opcode;
    logic [VALUE_BITS-1:0] operand;
  } in_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] result_value;
    logic [1:0]            status;
  } out_t;

  typedef struct packed {
    logic idle;
    logic done;
  } stat_t;

endpackage

`default_nettype wire

// ----- sv/xor_linear_basis_engine.sv -----
// Top level of the XOR linear basis engine: input handshake and output register.
// Depends on xlb_pkg and instantiates xlb_core.
//
// The engine holds a GF(2) basis with one row per leading bit and runs one
// operation per input beat: insert, max xor, min, reduce and pack, and kth.
// Each beat yields exactly one result beat. Work runs on a row memory walked
// one row per cycle through one shared XOR/compare unit, so an item is taken
// only when the sequencer is idle. Insert, max xor and min scan the basis
// rows; kth walks the packed rows up to packed_count; reduce walks every row
// and, for each nonempty row, every row below it, then packs the nonempty
// rows. A finished result sits in the output register, and the next beat is
// accepted as soon as the sequencer has handed its result over. No clearing
// pass is needed after reset.
`default_nettype none

module xor_linear_basis_engine (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire xlb_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output xlb_pkg::out_t      out_data
);
  import xlb_pkg::*;

  stat_t stat;
  out_t  rsp;
  out_t  out_data_r;
  logic  out_valid_r, out_valid_nxt;
  logic  start, take;

  assign in_ready = stat.idle;
  assign start    = in_valid && in_ready;
  assign take     = stat.done && (!out_valid_r || out_ready);

  xlb_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .req   (in_data),
    .take  (take),
    .stat  (stat),
    .rsp   (rsp)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data_r <= rsp;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ----- sv/xlb_alu.sv -----
// Shared XOR and magnitude compare unit of the basis engine.
// Depends on xlb_pkg for the value width.
`default_nettype none

module xlb_alu (
  input  wire logic [xlb_pkg::VALUE_BITS-1:0] a,
  input  wire logic [xlb_pkg::VALUE_BITS-1:0] b,
  output logic      [xlb_pkg::VALUE_BITS-1:0] x,
  output logic                                gt
);
  import xlb_pkg::*;

  assign x  = a ^ b;
  assign gt = (x > a);

endmodule

`default_nettype wire

// ----- sv/xlb_core.sv -----
// Sequencer, basis row memory and packed row memory of the basis engine.
// Depends on xlb_pkg and instantiates xlb_alu.
`default_nettype none

module xlb_core (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire xlb_pkg::in_t  req,
  input  wire logic          take,
  output xlb_pkg::stat_t     stat,
  output xlb_pkg::out_t      rsp
);
  import xlb_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_BSCAN  = 8'b0000_0010,
    S_MSCAN  = 8'b0000_0100,
    S_KSCAN  = 8'b0000_1000,
    S_RLOADI = 8'b0001_0000,
    S_RJ     = 8'b0010_0000,
    S_PSCAN  = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

  state_t                state_r, state_nxt;
  logic [2:0]            op_r, op_nxt;
  logic [VALUE_BITS-1:0] v_r, v_nxt;
  logic [VALUE_BITS-1:0] opd_r, opd_nxt;
  logic [VALUE_BITS-1:0] w_r, w_nxt;
  logic [VALUE_BITS-1:0] res_r, res_nxt;
  logic [1:0]            st_r, st_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic [IDX_W-1:0]      jdx_r, jdx_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;

  logic [VALUE_BITS-1:0] bmem [VALUE_BITS];
  logic [VALUE_BITS-1:0] pmem [VALUE_BITS];
  logic [VALUE_BITS-1:0] bvld_r;
  logic [VALUE_BITS-1:0] brd_r;
  logic [VALUE_BITS-1:0] prd_r;

  logic [IDX_W-1:0]      baddr, paddr, bwaddr;
  logic [VALUE_BITS-1:0] bwdata;
  logic                  bwe, pwe, vld_set;

  logic [VALUE_BITS-1:0] alu_a, alu_b, alu_x;
  logic                  alu_gt;
  logic [VALUE_BITS-1:0] rowi_eff, rowj_eff, wj;
  logic                  range_err;

  function automatic logic [VALUE_BITS-1:0] low_mask(input logic [CNT_W-1:0] n);
    logic [VALUE_BITS-1:0] m;
    for (int b = 0; b < VALUE_BITS; b++) begin
      m[b] = (CNT_W'(b) < n);
    end
    return m;
  endfunction

  xlb_alu u_alu (
    .a  (alu_a),
    .b  (alu_b),
    .x  (alu_x),
    .gt (alu_gt)
  );

  assign rowi_eff  = bvld_r[idx_r] ? brd_r : '0;
  assign rowj_eff  = bvld_r[jdx_r] ? brd_r : '0;
  assign wj        = w_r[jdx_r] ? alu_x : w_r;
  assign range_err = |(req.operand & ~low_mask(cnt_r));

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    v_nxt     = v_r;
    opd_nxt   = opd_r;
    w_nxt     = w_r;
    res_nxt   = res_r;
    st_nxt    = st_r;
    idx_nxt   = idx_r;
    jdx_nxt   = jdx_r;
    cnt_nxt   = cnt_r;
    baddr     = idx_r;
    paddr     = idx_r;
    bwe       = 1'b0;
    bwaddr    = idx_r;
    bwdata    = v_r;
    pwe       = 1'b0;
    vld_set   = 1'b0;
    alu_a     = v_r;
    alu_b     = rowi_eff;
    unique case (state_r)
      S_IDLE: begin
        baddr = (req.opcode == OP_MIN) ? '0 : TOP_IDX;
        paddr = '0;
        if (start) begin
          op_nxt  = req.opcode;
          v_nxt   = req.operand;
          opd_nxt = req.operand;
          res_nxt = '0;
          st_nxt  = ST_OK;
          unique case (req.opcode) inside
            OP_INSERT, OP_MAX: begin
              idx_nxt   = TOP_IDX;
              state_nxt = S_BSCAN;
            end
            OP_MIN: begin
              idx_nxt   = '0;
              state_nxt = S_MSCAN;
            end
            OP_REDUCE: begin
              idx_nxt   = TOP_IDX;
              state_nxt = S_RLOADI;
            end
            OP_KTH: begin
              idx_nxt = '0;
              if (range_err) begin
                st_nxt    = ST_RANGE;
                state_nxt = S_DONE;
              end else if (cnt_r == '0) begin
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_KSCAN;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_BSCAN: begin
        if (op_r == OP_INSERT && v_r[idx_r] && !bvld_r[idx_r]) begin
          bwe       = 1'b1;
          vld_set   = 1'b1;
          st_nxt    = ST_OK;
          state_nxt = S_DONE;
        end else begin
          if (op_r == OP_INSERT) begin
            if (v_r[idx_r]) begin
              v_nxt = alu_x;
            end
          end else if (alu_gt) begin
            v_nxt = alu_x;
          end
          if (idx_r == '0) begin
            state_nxt = S_DONE;
            if (op_r == OP_INSERT) begin
              st_nxt = ST_DEPENDENT;
            end else begin
              res_nxt = v_nxt;
            end
          end else begin
            idx_nxt = idx_r - IDX_W'(1);
            baddr   = idx_r - IDX_W'(1);
          end
        end
      end
      S_MSCAN: begin
        if (bvld_r[idx_r]) begin
          res_nxt   = brd_r;
          state_nxt = S_DONE;
        end else if (idx_r == TOP_IDX) begin
          st_nxt    = ST_EMPTY;
          state_nxt = S_DONE;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
          baddr   = idx_r + IDX_W'(1);
        end
      end
      S_KSCAN: begin
        alu_a = res_r;
        alu_b = prd_r;
        if (opd_r[idx_r]) begin
          res_nxt = alu_x;
        end
        if (CNT_W'(idx_r) + CNT_W'(1) == cnt_r) begin
          state_nxt = S_DONE;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
          paddr   = idx_r + IDX_W'(1);
        end
      end
      S_RLOADI: begin
        if (idx_r == '0) begin
          cnt_nxt   = '0;
          baddr     = '0;
          state_nxt = S_PSCAN;
        end else if (bvld_r[idx_r]) begin
          w_nxt     = brd_r;
          jdx_nxt   = idx_r - IDX_W'(1);
          baddr     = idx_r - IDX_W'(1);
          state_nxt = S_RJ;
        end else begin
          idx_nxt = idx_r - IDX_W'(1);
          baddr   = idx_r - IDX_W'(1);
        end
      end
      S_RJ: begin
        alu_a = w_r;
        alu_b = rowj_eff;
        w_nxt = wj;
        if (jdx_r == '0) begin
          bwe       = 1'b1;
          bwdata    = wj;
          idx_nxt   = idx_r - IDX_W'(1);
          baddr     = idx_r - IDX_W'(1);
          state_nxt = S_RLOADI;
        end else begin
          jdx_nxt = jdx_r - IDX_W'(1);
          baddr   = jdx_r - IDX_W'(1);
        end
      end
      S_PSCAN: begin
        if (bvld_r[idx_r]) begin
          pwe     = 1'b1;
          cnt_nxt = cnt_r + CNT_W'(1);
        end
        if (idx_r == TOP_IDX) begin
          state_nxt = S_DONE;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
          baddr   = idx_r + IDX_W'(1);
        end
      end
      S_DONE: begin
        if (take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      bvld_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (vld_set) begin
        bvld_r[idx_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    v_r   <= v_nxt;
    opd_r <= opd_nxt;
    w_r   <= w_nxt;
    res_r <= res_nxt;
    st_r  <= st_nxt;
    idx_r <= idx_nxt;
    jdx_r <= jdx_nxt;
  end

  always_ff @(posedge clk) begin
    if (bwe) begin
      bmem[bwaddr] <= bwdata;
    end
    brd_r <= bmem[baddr];
  end

  always_ff @(posedge clk) begin
    if (pwe) begin
      pmem[cnt_r[IDX_W-1:0]] <= brd_r;
    end
    prd_r <= pmem[paddr];
  end

  assign stat.idle         = (state_r == S_IDLE);
  assign stat.done         = (state_r == S_DONE);
  assign rsp.result_value  = res_r;
  assign rsp.status        = st_r;

endmodule

`default_nettype wire

// ----- tb/sv/xlb_sb_pkg.sv -----
// Scoreboard for the XOR linear basis engine testbench: a GF(2) basis predictor
// and the queue of answers it expects, one per accepted input beat.
// Depends on xlb_pkg.
package xlb_sb_pkg;
  timeunit 1ns;
  timeprecision 1ps;

  import xlb_pkg::*;

  class basis_scoreboard;
    logic [VALUE_BITS-1:0] basis_row [VALUE_BITS];
    logic [VALUE_BITS-1:0] packed_row [VALUE_BITS];
    int unsigned           rank_packed;
    out_t                  pending_answers [$];
    int unsigned           mismatches;

    function new();
      foreach (basis_row[i]) begin
        basis_row[i]  = '0;
        packed_row[i] = '0;
      end
      rank_packed = 0;
      mismatches  = 0;
    endfunction

    function out_t apply_op(in_t beat);
      out_t                  answer;
      logic [VALUE_BITS-1:0] v;
      logic                  placed;
      answer = '0;
      v      = beat.operand;
      placed = 1'b0;
      case (beat.opcode)
        OP_INSERT: begin
          answer.status = ST_DEPENDENT;
          for (int i = VALUE_BITS - 1; i >= 0; i--) begin
            if (!placed && v[i]) begin
              if (basis_row[i] == '0) begin
                basis_row[i]  = v;
                answer.status = ST_OK;
                placed        = 1'b1;
              end else begin
                v ^= basis_row[i];
              end
            end
          end
        end
        OP_MAX: begin
          for (int i = VALUE_BITS - 1; i >= 0; i--) begin
            if ((v ^ basis_row[i]) > v) v ^= basis_row[i];
          end
          answer.result_value = v;
        end
        OP_MIN: begin
          answer.status = ST_EMPTY;
          for (int i = 0; i < VALUE_BITS; i++) begin
            if (answer.status == ST_EMPTY && basis_row[i] != '0) begin
              answer.result_value = basis_row[i];
              answer.status       = ST_OK;
            end
          end
        end
        OP_REDUCE: begin
          for (int i = VALUE_BITS - 1; i >= 0; i--) begin
            for (int j = i - 1; j >= 0; j--) begin
              if (basis_row[i][j]) basis_row[i] ^= basis_row[j];
            end
          end
          rank_packed = 0;
          foreach (packed_row[i]) packed_row[i] = '0;
          for (int i = 0; i < VALUE_BITS; i++) begin
            if (basis_row[i] != '0) begin
              packed_row[rank_packed] = basis_row[i];
              rank_packed++;
            end
          end
        end
        OP_KTH: begin
          if ((v >> rank_packed) != '0) begin
            answer.status = ST_RANGE;
          end else begin
            for (int i = 0; i < rank_packed; i++) begin
              if (v[i]) answer.result_value ^= packed_row[i];
            end
          end
        end
        default: begin
        end
      endcase
      return answer;
    endfunction

    function void note_input(in_t beat);
      pending_answers.push_back(apply_op(beat));
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected result beat: expected none, got value %h status %0d",
                 $time, got.result_value, got.status);
        mismatches++;
        return;
      end
      want = pending_answers.pop_front();
      if (got.result_value !== want.result_value) begin
        $display("%0t: result_value mismatch: expected %h, got %h",
                 $time, want.result_value, got.result_value);
        mismatches++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status mismatch: expected %0d, got %0d",
                 $time, want.status, got.status);
        mismatches++;
      end
    endfunction
  endclass

endpackage

// ----- tb/sv/tb_top.sv -----
// Top-level testbench for xor_linear_basis_engine: directed and random operation
// beats with random idling on both channels, checked by the basis scoreboard.
// Depends on xlb_pkg, xlb_sb_pkg and the engine RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import xlb_pkg::*;
  import xlb_sb_pkg::*;

  localparam logic [2:0]            OP_UNUSED_FIRST = 3'd5;
  localparam logic [2:0]            OP_UNUSED_MID   = 3'd6;
  localparam logic [2:0]            OP_UNUSED_LAST  = 3'd7;
  localparam logic [VALUE_BITS-1:0] ALL_ONES        = '1;
  localparam logic [VALUE_BITS-1:0] NO_BITS         = '0;
  localparam logic [VALUE_BITS-1:0] ALT_BITS        =
    VALUE_BITS'({(VALUE_BITS + 1) / 2{2'b01}});
  localparam int                    RANDOM_PER_PHASE = 633;
  localparam int                    HOLD_CYCLES      = 3000;
  localparam int                    DRAIN_CYCLES     = 2200;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  basis_scoreboard       sb;
  int unsigned           in_idle_pct;
  int unsigned           out_idle_pct;
  logic                  hold_req;
  logic                  hold_started;
  int unsigned           hold_left;
  logic [VALUE_BITS-1:0] allowed_bits;

  xor_linear_basis_engine DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #200ms;
    $display("TEST FAILED");
    $finish;
  end

  always @(negedge clk) begin
    if (hold_req && !hold_started) begin
      hold_started <= 1'b1;
      hold_left    <= HOLD_CYCLES;
      out_ready    <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  function automatic logic [VALUE_BITS-1:0] rand_value();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[VALUE_BITS-1:0];
  endfunction

  function automatic in_t make_random_beat();
    in_t                   beat;
    int unsigned           pick;
    int unsigned           sel;
    logic [VALUE_BITS-1:0] v;
    logic [VALUE_BITS-1:0] span;
    pick = $urandom_range(0, 99);
    sel  = $urandom_range(0, 99);
    v    = rand_value();
    if (pick < 40) begin
      beat.opcode = OP_INSERT;
      if (sel < 55) begin
        v = v & allowed_bits;
      end else if (sel < 87) begin
        v = '0;
        foreach (sb.basis_row[i]) begin
          if (sb.basis_row[i] != '0 && $urandom_range(0, 1) == 1) v ^= sb.basis_row[i];
        end
      end else if (sel < 99) begin
        v = '0;
      end
    end else if (pick < 55) begin
      beat.opcode = OP_MAX;
      if (sel < 50) v = v & allowed_bits;
    end else if (pick < 63) begin
      beat.opcode = OP_MIN;
    end else if (pick < 69) begin
      beat.opcode = OP_REDUCE;
    end else if (pick < 96) begin
      beat.opcode = OP_KTH;
      span = (VALUE_BITS'(1) << sb.rank_packed) - VALUE_BITS'(1);
      if (sel < 70) v = v & span;
      else if (sel < 78) v = span;
      else if (sel < 86) v = span + VALUE_BITS'(1);
    end else begin
      beat.opcode = 3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
    end
    beat.operand = v;
    return beat;
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_beat(in_t beat);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(0, 99) < in_idle_pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
    sb.note_input(beat);
    @(negedge clk);
  endtask

  initial begin
    sb           = new();
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    out_ready    = 1'b0;
    hold_req     = 1'b0;
    hold_started = 1'b0;
    hold_left    = 0;
    in_idle_pct  = 20;
    out_idle_pct = 50;
    allowed_bits = '0;
    repeat (4) allowed_bits[$urandom_range(0, VALUE_BITS - 1)] = 1'b1;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_beat({OP_MIN, NO_BITS});
    send_beat({OP_MAX, ALL_ONES});
    send_beat({OP_MAX, NO_BITS});
    send_beat({OP_KTH, NO_BITS});
    send_beat({OP_KTH, VALUE_BITS'(1)});
    send_beat({OP_REDUCE, NO_BITS});
    send_beat({OP_INSERT, NO_BITS});
    send_beat({OP_INSERT, ALL_ONES});
    send_beat({OP_INSERT, ALL_ONES});
    send_beat({OP_INSERT, VALUE_BITS'(1)});
    send_beat({OP_INSERT, VALUE_BITS'(1) << (VALUE_BITS - 1)});
    send_beat({OP_MIN, ALL_ONES});
    send_beat({OP_MAX, NO_BITS});
    send_beat({OP_KTH, VALUE_BITS'(1)});
    send_beat({OP_REDUCE, ALL_ONES});
    send_beat({OP_KTH, NO_BITS});
    send_beat({OP_KTH, VALUE_BITS'(1)});
    send_beat({OP_KTH, VALUE_BITS'(7)});
    send_beat({OP_KTH, VALUE_BITS'(8)});
    send_beat({OP_KTH, ALL_ONES});
    send_beat({OP_INSERT, ALT_BITS});
    send_beat({OP_KTH, VALUE_BITS'(7)});
    send_beat({OP_UNUSED_FIRST, ALL_ONES});
    send_beat({OP_UNUSED_MID, ALL_ONES});
    send_beat({OP_UNUSED_LAST, ALL_ONES});

    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        in_idle_pct  = 50;
        out_idle_pct = 20;
      end else if (phase == 2) begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (n % 30 == 29) allowed_bits[$urandom_range(0, VALUE_BITS - 1)] = 1'b1;
        send_beat(make_random_beat());
        if (phase == 1 && n == 150) hold_req <= 1'b1;
      end
    end
    in_valid <= 1'b0;

    while (sb.pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_answers.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
